/* sv/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/hcdm_pkg.sv */
package hcdm_pkg;

  localparam int COUNT_W   = 16;
  localparam int DIST_W    = 23;
  localparam int FRAC_BITS = 21;
  localparam int POS_W     = 6;
  localparam int CENTER_W  = 5;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 5'd20;
  localparam logic [POS_W-1:0]    POS_MAX      = 6'd63;

  typedef struct packed {
    logic [COUNT_W-1:0] leaves_a;
    logic [COUNT_W-1:0] ref_a;
    logic [COUNT_W-1:0] unk_a;
    logic [COUNT_W-1:0] leaves_b;
    logic [COUNT_W-1:0] ref_b;
    logic [COUNT_W-1:0] unk_b;
  } var_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] merged_ref;
    logic [COUNT_W-1:0] merged_unk;
    logic [COUNT_W-1:0] merged_leaves;
    logic [DIST_W-1:0]  weight;
  } eval_out_t;

endpackage

/* sv/hcdm_eval.sv */
module hcdm_eval #(
  parameter int COUNT_BITS = 16,
  parameter int MAX_SIDE   = 20
) (
  input  logic [hcdm_pkg::CENTER_W-1:0] center,
  input  logic [hcdm_pkg::POS_W-1:0]    pos,
  input  hcdm_pkg::var_item_t           item,
  output hcdm_pkg::eval_out_t           res
);

  function automatic logic ref_major(input logic [COUNT_BITS-1:0] leaves,
                                     input logic [COUNT_BITS-1:0] refc,
                                     input logic [COUNT_BITS-1:0] unk);
    logic [COUNT_BITS-1:0] alt;
    alt = leaves - refc - unk;
    return refc >= alt;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] x,
                                                    input logic [COUNT_BITS-1:0] y);
    logic [COUNT_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  logic [COUNT_BITS-1:0] la, ra, ua, lb, rb, ub;
  logic [hcdm_pkg::POS_W-1:0] center_ext, d;
  logic left, near, maj_a, maj_b, unk_diff;
  logic [hcdm_pkg::CENTER_W-1:0] sh_major, sh_unk;

  assign la = item.leaves_a[COUNT_BITS-1:0];
  assign ra = item.ref_a[COUNT_BITS-1:0];
  assign ua = item.unk_a[COUNT_BITS-1:0];
  assign lb = item.leaves_b[COUNT_BITS-1:0];
  assign rb = item.ref_b[COUNT_BITS-1:0];
  assign ub = item.unk_b[COUNT_BITS-1:0];

  assign center_ext = {1'b0, center};
  assign left       = pos <= center_ext;
  assign d          = left ? center_ext - pos : pos - center_ext;
  assign near       = d <= hcdm_pkg::POS_W'(MAX_SIDE);

  assign maj_a    = ref_major(la, ra, ua);
  assign maj_b    = ref_major(lb, rb, ub);
  assign unk_diff = (ua != '0) != (ub != '0);

  // Only used when the variant is near, so d is at most MAX_SIDE (20) and the shifts stay non-negative.
  assign sh_major = hcdm_pkg::CENTER_W'(hcdm_pkg::FRAC_BITS) - d[hcdm_pkg::CENTER_W-1:0];
  assign sh_unk   = sh_major - 5'd1;

  always_comb begin
    res.merged_ref    = hcdm_pkg::COUNT_W'(sat_add(ra, rb));
    res.merged_unk    = hcdm_pkg::COUNT_W'(sat_add(ua, ub));
    res.merged_leaves = hcdm_pkg::COUNT_W'(sat_add(la, lb));
    res.weight        = '0;
    if (near) begin
      if (maj_a != maj_b) begin
        res.weight = hcdm_pkg::DIST_W'(1) << sh_major;
      end else if (left && unk_diff) begin
        res.weight = hcdm_pkg::DIST_W'(1) << sh_unk;
      end
    end
  end

endmodule

/* sv/haplotype_cluster_distance_merge_core.sv */
// Center-weighted distance and merge of two haplotype clusters. Each input item
// carries one variant's leaf, reference and unknown counts for both clusters, and
// yields one result item with the saturating merged counts and the running
// distance (23 bits, 21 fraction bits); the result that answers the item marked
// with s_tlast holds the final distance and is itself marked with m_tlast, and
// the window position and distance then restart at zero for the next pair. An
// item passes the input register, then the result register; one item is taken
// every cycle unless m_tready stalls the output, and the distance accumulator is
// written with the result. The user must write center_index (reset 20) through
// cfg_we/cfg_wdata only while no item is in flight; the core does not enforce it.
`include "assert_macros.svh"

module haplotype_cluster_distance_merge_core #(
  parameter int COUNT_BITS = 16,
  parameter int MAX_SIDE   = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // leaves_a, ref_a, unk_a, leaves_b, ref_b, unk_b (16 bits each, lowest first)
  input  logic [95:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // merged_ref [15:0], merged_unk [31:16], merged_leaves [47:32],
  // pair_distance [70:48], zero pad [71]
  output logic [71:0] m_tdata,
  output logic        m_tlast
);

  logic [hcdm_pkg::CENTER_W-1:0] center_index;
  logic [hcdm_pkg::POS_W-1:0]    variant_position, variant_position_next;
  logic [hcdm_pkg::DIST_W-1:0]   distance_sum, distance_sum_next;
  logic [hcdm_pkg::DIST_W:0]     sum_wide;

  logic                  s1_valid;
  logic                  s1_last;
  hcdm_pkg::var_item_t   s1_item;
  hcdm_pkg::eval_out_t   ev;
  logic                  out_adv;

  logic                            out_valid;
  logic                            out_final;
  logic [hcdm_pkg::COUNT_W-1:0]    out_ref, out_unk, out_leaves;
  logic [hcdm_pkg::DIST_W-1:0]     out_dist;

  hcdm_eval #(
    .COUNT_BITS(COUNT_BITS),
    .MAX_SIDE  (MAX_SIDE)
  ) u_eval (
    .center(center_index),
    .pos   (variant_position),
    .item  (s1_item),
    .res   (ev)
  );

  assign out_adv  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || out_adv;

  assign sum_wide          = {1'b0, distance_sum} + {1'b0, ev.weight};
  assign distance_sum_next = sum_wide[hcdm_pkg::DIST_W] ? '1
                                                        : sum_wide[hcdm_pkg::DIST_W-1:0];

  always_comb begin
    if (s1_last) begin
      variant_position_next = '0;
    end else if (variant_position < hcdm_pkg::POS_MAX) begin
      variant_position_next = variant_position + 6'd1;
    end else begin
      variant_position_next = hcdm_pkg::POS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_index     <= hcdm_pkg::CENTER_RESET;
      variant_position <= '0;
      distance_sum     <= '0;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        center_index <= cfg_wdata;
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_adv) begin
        out_valid        <= 1'b1;
        variant_position <= variant_position_next;
        distance_sum     <= s1_last ? '0 : distance_sum_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item.leaves_a <= s_tdata[15:0];
      s1_item.ref_a    <= s_tdata[31:16];
      s1_item.unk_a    <= s_tdata[47:32];
      s1_item.leaves_b <= s_tdata[63:48];
      s1_item.ref_b    <= s_tdata[79:64];
      s1_item.unk_b    <= s_tdata[95:80];
      s1_last          <= s_tlast;
    end
    if (out_adv) begin
      out_ref    <= ev.merged_ref;
      out_unk    <= ev.merged_unk;
      out_leaves <= ev.merged_leaves;
      out_dist   <= distance_sum_next;
      out_final  <= s1_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_dist, out_leaves, out_unk, out_ref};
  assign m_tlast  = out_final;

  // A window's distance only grows until its last variant.
  `ASSERT_NEXT(a_dist_grows, clk, rst, out_adv && !s1_last, distance_sum >= $past(distance_sum))
  // The last variant of a window leaves the state cleared for the next pair.
  `ASSERT_NEXT(a_window_clear, clk, rst, out_adv && s1_last,
               variant_position == '0 && distance_sum == '0)
  // Within a window the shown distance is the accumulator just written.
  `ASSERT_NEXT(a_dist_shown, clk, rst, out_adv && !s1_last, out_dist == distance_sum)

endmodule
